FILE: rtl/core/ttwa_pkg.sv
// ----------------------------------------------------------------------------
// ttwa_pkg
// shared widths, codes and parameter defaults of the tiled texture write
// address core
// ----------------------------------------------------------------------------
package ttwa_pkg;

  localparam int ADDR_W   = 25;
  localparam int COORD_W  = 10;
  localparam int PIXEL_W  = 32;
  localparam int WORD_W   = 16;
  localparam int BE_W     = 2;
  localparam int WLOG2_W  = 4;
  localparam int TEXEL_W  = 4;

  localparam int IN_DATA_W  = 80;
  localparam int OUT_DATA_W = 48;

  localparam int DEF_MEM_WORDS      = 16777216;
  localparam int DEF_MAX_WIDTH_LOG2 = 10;

  typedef enum logic [1:0] {
    FMT_RGB565   = 2'd0,
    FMT_RGBA8888 = 2'd1,
    FMT_R8       = 2'd2,
    FMT_LINEAR   = 2'd3
  } tex_format_t;

  typedef enum logic [1:0] {
    REG_BASE_ADDR      = 2'd0,
    REG_WIDTH_LOG2     = 2'd1,
    REG_TEXTURE_FORMAT = 2'd2,
    REG_UNUSED         = 2'd3
  } reg_index_t;

  localparam logic [BE_W-1:0] BE_LOW  = 2'b01;
  localparam logic [BE_W-1:0] BE_HIGH = 2'b10;
  localparam logic [BE_W-1:0] BE_WORD = 2'b11;

endpackage

FILE: rtl/core/tiled_texture_write_address_core.sv
// ----------------------------------------------------------------------------
// tiled_texture_write_address_core
// turns texels or linear words into 16-bit memory write commands for a
// texture stored in 4x4 texel blocks
// ----------------------------------------------------------------------------
// Usage:
//   s_* stream carries one texel or linear word per transaction; m_* stream
//   carries write commands, m_tlast marks the final write of an input.
//   cfg_* writes base_addr (0), width exponent (1), texture_format (2); index
//   3 is ignored. cfg_ready is always high; write only while the core is idle.
// Pipeline: three register stages; an input passes stage 1, stage 2 and the
//   output register (stage 3) before its first write leaves.
// Throughput: one input per cycle for RGB565, R8 and linear unless the output
//   stalls; RGBA8888 takes the next input only when its second beat is taken.
// Stall: when the output stage holds a write that is not taken, the whole
//   pipeline holds and s_tready drops in the same cycle; nothing is lost.
// Reset: rst clears all valid bits and the config registers to zero (RGB565,
//   base 0, width exponent 0).
// ----------------------------------------------------------------------------
module tiled_texture_write_address_core #(
  parameter int MEM_WORDS      = ttwa_pkg::DEF_MEM_WORDS,
  parameter int MAX_WIDTH_LOG2 = ttwa_pkg::DEF_MAX_WIDTH_LOG2
) (
  input  logic                               clk,
  input  logic                               rst,
  // config write channel
  input  logic                               cfg_valid,
  output logic                               cfg_ready,
  input  logic [1:0]                         cfg_index,
  input  logic [ttwa_pkg::ADDR_W-1:0]        cfg_data,
  // texel_x[9:0], texel_y[19:10], pixel_value[51:20], word_index[76:52]
  input  logic                               s_tvalid,
  output logic                               s_tready,
  input  logic [ttwa_pkg::IN_DATA_W-1:0]     s_tdata,
  // wr_addr[24:0], word_data[40:25], byte_enable[42:41], write_valid[43]
  output logic                               m_tvalid,
  input  logic                               m_tready,
  output logic [ttwa_pkg::OUT_DATA_W-1:0]    m_tdata,
  output logic                               m_tlast
);
  import ttwa_pkg::*;

  localparam int BLK_W = MAX_WIDTH_LOG2 + 6;
  localparam logic [ADDR_W:0] MEM_LIMIT = (ADDR_W+1)'(MEM_WORDS);
  localparam logic [WLOG2_W-1:0] MAX_WL = WLOG2_W'(MAX_WIDTH_LOG2);

  // config registers
  logic [ADDR_W-1:0]  base_addr;
  logic [WLOG2_W-1:0] tex_wlog2;
  tex_format_t        texture_format;

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      base_addr      <= '0;
      tex_wlog2      <= '0;
      texture_format <= FMT_RGB565;
    end else if (cfg_valid) begin
      case (reg_index_t'(cfg_index))
        REG_BASE_ADDR:      base_addr      <= cfg_data;
        REG_WIDTH_LOG2:     tex_wlog2      <= cfg_data[WLOG2_W-1:0];
        REG_TEXTURE_FORMAT: texture_format <= tex_format_t'(cfg_data[1:0]);
        default: ;
      endcase
    end
  end

  // input unpack
  logic [COORD_W-1:0] in_x, in_y;
  logic [PIXEL_W-1:0] in_pix;
  logic [ADDR_W-1:0]  in_widx;
  assign in_x    = s_tdata[9:0];
  assign in_y    = s_tdata[19:10];
  assign in_pix  = s_tdata[51:20];
  assign in_widx = s_tdata[76:52];

  // pipeline control
  logic s1_valid, s2_valid, s3_valid;
  logic s3_two, s3_beat;
  logic out_done, advance;

  assign out_done = m_tvalid && m_tready && (!s3_two || s3_beat);
  assign advance  = !s3_valid || out_done;
  assign s_tready = advance;

  // stage 1: block and texel index
  logic [WLOG2_W-1:0] wl_clamped, blk_shift;
  logic [BLK_W-1:0]   blk_next;
  logic [BLK_W-1:0]   s1_blk;
  logic [TEXEL_W-1:0] s1_texel;
  logic [PIXEL_W-1:0] s1_pix;
  logic [ADDR_W-1:0]  s1_widx;

  always_comb begin
    wl_clamped = (tex_wlog2 > MAX_WL) ? MAX_WL : tex_wlog2;
    blk_shift  = (wl_clamped >= WLOG2_W'(2)) ? wl_clamped - WLOG2_W'(2) : '0;
    blk_next   = (BLK_W'(in_y[COORD_W-1:2]) << blk_shift) | BLK_W'(in_x[COORD_W-1:2]);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
    end else if (advance) begin
      s1_valid <= s_tvalid;
    end
  end

  always_ff @(posedge clk) begin
    if (advance) begin
      s1_blk   <= blk_next;
      s1_texel <= {in_y[1:0], in_x[1:0]};
      s1_pix   <= in_pix;
      s1_widx  <= in_widx;
    end
  end

  // stage 2: address, data and lanes
  logic [ADDR_W-1:0] offset;
  logic [WORD_W-1:0] data_lo_next;
  logic [BE_W-1:0]   be_next;
  logic [ADDR_W-1:0] s2_addr;
  logic [WORD_W-1:0] s2_data_lo, s2_data_hi;
  logic [BE_W-1:0]   s2_be;
  logic              s2_two;

  always_comb begin
    offset       = ADDR_W'({s1_blk, s1_texel});
    data_lo_next = s1_pix[WORD_W-1:0];
    be_next      = BE_WORD;
    case (texture_format)
      FMT_RGB565:   offset = ADDR_W'({s1_blk, s1_texel});
      FMT_RGBA8888: offset = ADDR_W'({s1_blk, s1_texel, 1'b0});
      FMT_R8: begin
        offset = ADDR_W'({s1_blk, s1_texel[TEXEL_W-1:1]});
        if (s1_texel[0]) begin
          data_lo_next = {s1_pix[7:0], 8'h00};
          be_next      = BE_HIGH;
        end else begin
          data_lo_next = {8'h00, s1_pix[7:0]};
          be_next      = BE_LOW;
        end
      end
      FMT_LINEAR:   offset = s1_widx;
      default:      offset = s1_widx;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      s2_valid <= 1'b0;
    end else if (advance) begin
      s2_valid <= s1_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (advance) begin
      s2_addr    <= base_addr + offset;
      s2_data_lo <= data_lo_next;
      s2_data_hi <= s1_pix[PIXEL_W-1:WORD_W];
      s2_be      <= be_next;
      s2_two     <= (texture_format == FMT_RGBA8888);
    end
  end

  // stage 3: output register, one or two beats
  logic [ADDR_W-1:0] addr_hi_next;
  logic [ADDR_W-1:0] s3_addr_lo, s3_addr_hi;
  logic              s3_ok_lo, s3_ok_hi;
  logic [WORD_W-1:0] s3_data_lo, s3_data_hi;
  logic [BE_W-1:0]   s3_be;

  assign addr_hi_next = s2_addr + ADDR_W'(1);

  always_ff @(posedge clk) begin
    if (rst) begin
      s3_valid <= 1'b0;
      s3_beat  <= 1'b0;
    end else if (advance) begin
      s3_valid <= s2_valid;
      s3_beat  <= 1'b0;
    end else if (m_tvalid && m_tready) begin
      s3_beat <= 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (advance) begin
      s3_addr_lo <= s2_addr;
      s3_addr_hi <= addr_hi_next;
      s3_ok_lo   <= {1'b0, s2_addr} < MEM_LIMIT;
      s3_ok_hi   <= {1'b0, addr_hi_next} < MEM_LIMIT;
      s3_data_lo <= s2_data_lo;
      s3_data_hi <= s2_data_hi;
      s3_be      <= s2_be;
      s3_two     <= s2_two;
    end
  end

  assign m_tvalid = s3_valid;
  assign m_tlast  = !s3_two || s3_beat;
  assign m_tdata  = s3_beat ? {4'h0, s3_ok_hi, s3_be, s3_data_hi, s3_addr_hi}
                            : {4'h0, s3_ok_lo, s3_be, s3_data_lo, s3_addr_lo};

endmodule

FILE: verif/tb.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb
// self-checking bench for the tiled texture write address core: texels and
// linear words are streamed in under several register settings, a local
// model of the 4x4 block-tiled layout predicts every write command, and the
// output stream is compared field by field while both sides stall at random
// ----------------------------------------------------------------------------
module tb;
  import ttwa_pkg::*;

  localparam int MEM_WORDS      = DEF_MEM_WORDS;
  localparam int MAX_WIDTH_LOG2 = DEF_MAX_WIDTH_LOG2;
  localparam int RANDOM_PHASES  = 16;
  localparam int PHASE_ITEMS    = 100;

  typedef struct {
    logic [ADDR_W-1:0] addr;
    logic [WORD_W-1:0] data;
    logic [BE_W-1:0]   be;
    logic              wv;
    logic              last;
  } write_cmd_t;

  logic                  clk;
  logic                  rst;
  logic                  cfg_valid;
  logic                  cfg_ready;
  logic [1:0]            cfg_index;
  logic [ADDR_W-1:0]     cfg_data;
  logic                  s_tvalid;
  logic                  s_tready;
  logic [IN_DATA_W-1:0]  s_tdata;
  logic                  m_tvalid;
  logic                  m_tready;
  logic [OUT_DATA_W-1:0] m_tdata;
  logic                  m_tlast;

  logic [ADDR_W-1:0]  shadow_base;
  logic [WLOG2_W-1:0] shadow_wlog2;
  tex_format_t        shadow_fmt;

  write_cmd_t pending_writes[$];
  int         mismatches;
  bit         idle_en;
  int         stall_left;

  tiled_texture_write_address_core #(
    .MEM_WORDS(MEM_WORDS),
    .MAX_WIDTH_LOG2(MAX_WIDTH_LOG2)
  ) dut (
    .clk(clk),
    .rst(rst),
    .cfg_valid(cfg_valid),
    .cfg_ready(cfg_ready),
    .cfg_index(cfg_index),
    .cfg_data(cfg_data),
    .s_tvalid(s_tvalid),
    .s_tready(s_tready),
    .s_tdata(s_tdata),
    .m_tvalid(m_tvalid),
    .m_tready(m_tready),
    .m_tdata(m_tdata),
    .m_tlast(m_tlast)
  );

  initial begin
    clk = 1'b0;
    forever #10 clk = ~clk;
  end

  initial begin
    #20000000;
    $display("Verification failed");
    $finish;
  end

  // output side backpressure
  initial begin
    m_tready = 1'b1;
    stall_left = 0;
    forever begin
      @(negedge clk);
      if (stall_left > 0) begin
        stall_left--;
        m_tready <= 1'b0;
      end else if (idle_en && $urandom_range(0, 5) == 0) begin
        stall_left = $urandom_range(1, 16) - 1;
        m_tready <= 1'b0;
      end else begin
        m_tready <= 1'b1;
      end
    end
  end

  function automatic write_cmd_t make_cmd(logic [ADDR_W-1:0] addr, logic [WORD_W-1:0] data,
                                          logic [BE_W-1:0] be, logic last);
    write_cmd_t c;
    c.addr = addr;
    c.data = data;
    c.be   = be;
    c.wv   = (int'(addr) < MEM_WORDS);
    c.last = last;
    return c;
  endfunction

  function automatic void predict_writes(logic [COORD_W-1:0] x, logic [COORD_W-1:0] y,
                                         logic [PIXEL_W-1:0] pix, logic [ADDR_W-1:0] widx);
    int unsigned wl;
    int unsigned bl;
    int unsigned blk;
    int unsigned tx;
    bit [31:0]   sum;
    logic [ADDR_W-1:0] addr;
    wl  = (shadow_wlog2 > MAX_WIDTH_LOG2) ? MAX_WIDTH_LOG2 : shadow_wlog2;
    bl  = (wl >= 2) ? wl - 2 : 0;
    blk = ((int'(y) >> 2) << bl) | (int'(x) >> 2);
    tx  = (y[1:0] * 4) + x[1:0];
    case (shadow_fmt)
      FMT_RGB565: begin
        sum  = shadow_base + blk * 16 + tx;
        addr = sum[ADDR_W-1:0];
        pending_writes.push_back(make_cmd(addr, pix[15:0], BE_WORD, 1'b1));
      end
      FMT_RGBA8888: begin
        sum  = shadow_base + blk * 32 + tx * 2;
        addr = sum[ADDR_W-1:0];
        pending_writes.push_back(make_cmd(addr, pix[15:0], BE_WORD, 1'b0));
        pending_writes.push_back(make_cmd(addr + 1'b1, pix[31:16], BE_WORD, 1'b1));
      end
      FMT_R8: begin
        sum  = shadow_base + blk * 8 + (tx >> 1);
        addr = sum[ADDR_W-1:0];
        if (tx[0] == 1'b0)
          pending_writes.push_back(make_cmd(addr, {8'h00, pix[7:0]}, BE_LOW, 1'b1));
        else
          pending_writes.push_back(make_cmd(addr, {pix[7:0], 8'h00}, BE_HIGH, 1'b1));
      end
      default: begin
        sum  = shadow_base + widx;
        addr = sum[ADDR_W-1:0];
        pending_writes.push_back(make_cmd(addr, pix[15:0], BE_WORD, 1'b1));
      end
    endcase
  endfunction

  task automatic check_field(string name, logic [31:0] expected, logic [31:0] actual);
    if (expected !== actual) begin
      if (mismatches < 20)
        $display("%0t: %s mismatch, expected 0x%0h, actual 0x%0h", $time, name, expected,
                 actual);
      mismatches++;
    end
  endtask

  always @(posedge clk) begin
    write_cmd_t e;
    if (!rst && m_tvalid && m_tready) begin
      if (pending_writes.size() == 0) begin
        if (mismatches < 20)
          $display("%0t: unexpected write, expected none, actual addr 0x%0h data 0x%0h",
                   $time, m_tdata[24:0], m_tdata[40:25]);
        mismatches++;
      end else begin
        e = pending_writes.pop_front();
        check_field("wr_addr", e.addr, m_tdata[24:0]);
        check_field("word_data", e.data, m_tdata[40:25]);
        check_field("byte_enable", e.be, m_tdata[42:41]);
        check_field("write_valid", e.wv, m_tdata[43]);
        check_field("last", e.last, m_tlast);
      end
    end
  end

  // all stimulus tasks start and end at a falling edge
  task automatic send_texel(logic [COORD_W-1:0] x, logic [COORD_W-1:0] y,
                            logic [PIXEL_W-1:0] pix, logic [ADDR_W-1:0] widx);
    int gap;
    if (idle_en && $urandom_range(0, 4) == 0) begin
      gap = $urandom_range(1, 16);
      s_tvalid <= 1'b0;
      repeat (gap) @(negedge clk);
    end
    s_tvalid <= 1'b1;
    s_tdata  <= {3'b000, widx, pix, y, x};
    do @(posedge clk); while (!s_tready);
    predict_writes(x, y, pix, widx);
    @(negedge clk);
  endtask

  task automatic wait_idle();
    s_tvalid <= 1'b0;
    while (pending_writes.size() != 0) @(negedge clk);
    repeat (6) @(negedge clk);
  endtask

  task automatic cfg_write(reg_index_t idx, logic [ADDR_W-1:0] value);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= value;
    do @(posedge clk); while (!cfg_ready);
    case (idx)
      REG_BASE_ADDR:      shadow_base  = value;
      REG_WIDTH_LOG2:     shadow_wlog2 = value[WLOG2_W-1:0];
      REG_TEXTURE_FORMAT: shadow_fmt   = tex_format_t'(value[1:0]);
      default: ;
    endcase
    @(negedge clk);
    cfg_valid <= 1'b0;
    @(negedge clk);
  endtask

  task automatic configure(logic [ADDR_W-1:0] base, logic [WLOG2_W-1:0] wlog2,
                           tex_format_t fmt);
    wait_idle();
    cfg_write(REG_BASE_ADDR, base);
    cfg_write(REG_WIDTH_LOG2, ADDR_W'(wlog2));
    cfg_write(REG_TEXTURE_FORMAT, ADDR_W'(fmt));
  endtask

  task automatic test_reset_state();
    send_texel(10'd0, 10'd0, 32'h0000_0000, 25'd0);
    send_texel(10'd1023, 10'd1023, 32'hFFFF_FFFF, 25'h1FF_FFFF);
  endtask

  task automatic test_each_format();
    tex_format_t fmt;
    for (int f = 0; f < 4; f++) begin
      fmt = tex_format_t'(f);
      configure(25'd0, 4'd10, fmt);
      send_texel(10'd0, 10'd0, 32'h0000_0000, 25'd0);
      send_texel(10'd1023, 10'd1023, 32'hFFFF_FFFF, 25'h1FF_FFFF);
      send_texel(10'd5, 10'd2, 32'hA5C3_5A3C, 25'h0AA_AAAA);
      if (fmt == FMT_R8)
        send_texel(10'd2, 10'd1, 32'h1234_56C7, 25'd7);
    end
  endtask

  task automatic test_address_wrap();
    configure(25'h1FF_FFFF, 4'd4, FMT_RGBA8888);
    send_texel(10'd0, 10'd0, 32'hDEAD_BEEF, 25'd0);
    configure(25'h0FF_FFFF, 4'd2, FMT_RGB565);
    send_texel(10'd0, 10'd0, 32'h0000_1111, 25'd0);
    send_texel(10'd1, 10'd0, 32'h0000_2222, 25'd0);
    configure(25'h1FF_FFFF, 4'd0, FMT_LINEAR);
    send_texel(10'd0, 10'd0, 32'h0000_3333, 25'd1);
    wait_idle();
    cfg_write(REG_UNUSED, 25'h155_5555);
    send_texel(10'd7, 10'd9, 32'h0000_4444, 25'h1FF_FFFF);
  endtask

  task automatic test_oversized_width();
    configure(25'd0, 4'd15, FMT_RGB565);
    send_texel(10'd1023, 10'd1023, 32'h0000_5555, 25'd0);
    configure(25'd0, 4'd11, FMT_RGBA8888);
    send_texel(10'd4, 10'd1020, 32'h6666_7777, 25'd0);
    configure(25'd12345, 4'd1, FMT_R8);
    send_texel(10'd1023, 10'd4, 32'h0000_00FF, 25'd0);
  endtask

  task automatic test_random_traffic();
    logic [ADDR_W-1:0]  base;
    logic [WLOG2_W-1:0] wlog2;
    tex_format_t        fmt;
    for (int p = 0; p < RANDOM_PHASES; p++) begin
      case ($urandom_range(0, 4))
        0:       base = '0;
        1:       base = '1;
        2:       base = 25'h100_0000 - 25'($urandom_range(1, 4096));
        default: base = 25'($urandom());
      endcase
      wlog2 = 4'($urandom_range(0, 15));
      fmt   = tex_format_t'($urandom_range(0, 3));
      configure(base, wlog2, fmt);
      if ($urandom_range(0, 3) == 0)
        cfg_write(REG_UNUSED, 25'($urandom()));
      idle_en = (p < RANDOM_PHASES - 2) ? ($urandom_range(0, 3) != 0) : 1'b0;
      for (int i = 0; i < PHASE_ITEMS; i++)
        send_texel(10'($urandom()), 10'($urandom()), $urandom(), 25'($urandom()));
    end
  endtask

  initial begin
    rst          = 1'b1;
    cfg_valid    = 1'b0;
    cfg_index    = '0;
    cfg_data     = '0;
    s_tvalid     = 1'b0;
    s_tdata      = '0;
    shadow_base  = '0;
    shadow_wlog2 = '0;
    shadow_fmt   = FMT_RGB565;
    mismatches   = 0;
    idle_en      = 1'b1;
    repeat (8) @(negedge clk);
    rst <= 1'b0;
    @(negedge clk);

    test_reset_state();
    test_each_format();
    test_address_wrap();
    test_oversized_width();
    test_random_traffic();

    wait_idle();
    repeat (10) @(posedge clk);
    if (mismatches == 0 && pending_writes.size() == 0)
      $display("Verification passed");
    else
      $display("Verification failed");
    $finish;
  end

endmodule
